@@ sv/crpm_pkg.sv @@
package crpm_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_SIDE_DEF  = 4096;
   localparam int FRAC_BITS_DEF = 4;

   // Configuration port.
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int FRAME_W     = 13;
   localparam int CENTER_W    = 17;
   localparam int RADIUS_W    = 16;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_X     = 3'd0,
      REG_CENTER_Y     = 3'd1,
      REG_RADIUS       = 3'd2,
      REG_FILL_MODE    = 3'd3,
      REG_FRAME_WIDTH  = 3'd4,
      REG_FRAME_HEIGHT = 3'd5
   } csr_reg_type;

   // Luminance weights in thousandths, and the reciprocal of 1000 used to
   // divide their sum: floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for x < 2^18.
   localparam int WSUM_W      = 18;
   localparam int LUMA_R      = 299;
   localparam int LUMA_G      = 587;
   localparam int LUMA_B      = 114;
   localparam int RECIP_W     = 19;
   localparam int RECIP       = 268436;
   localparam int RECIP_SHIFT = 28;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic [RADIUS_W-1:0]        radius;
      logic                       fill_mode;
      logic [FRAME_W-1:0]         frame_width;
      logic [FRAME_W-1:0]         frame_height;
   } csr_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   typedef struct packed {
      color_type  color;
      logic [7:0] gray_level;
      logic       is_inside;
      logic       frame_end;
   } result_type;

   // Frame side as used by the counters: zero acts as one, and anything
   // above the largest side acts as the largest side.
   function automatic int clamp_side(logic [FRAME_W-1:0] side, int max_side);
      int v;
      v = int'(side);
      if (v < 1) begin
         return 1;
      end
      if (v > max_side) begin
         return max_side;
      end
      return v;
   endfunction

endpackage

@@ sv/circle_ring_pixel_mask.sv @@
// Channel   Direction  Ports                                          Handshake
// req       in         color_red/green/blue/alpha, shift_x, shift_y   req_valid / req_ready
// rsp       out        out_red/green/blue/alpha, gray_level,          rsp_valid / rsp_ready
//                      is_inside, frame_end
// csr       in         csr_index, csr_wdata                           csr_write
//
// Each word passes through an input register, then the distance test and luminance divide
// feeding the result register.
// One word is accepted per cycle unless a stalled result backs up the input register; the
// two squarers and the reciprocal multiply set the critical path between the two registers.
// Reset clears the counters, the configuration and both valid flags.
// A stalled result holds its register while the input register still takes one more word.
module circle_ring_pixel_mask
   import crpm_pkg::*;
#(
   parameter int MAX_SIDE  = MAX_SIDE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_color_red,
   input  logic [7:0]              req_color_green,
   input  logic [7:0]              req_color_blue,
   input  logic [7:0]              req_color_alpha,
   input  logic signed [11:0]      req_shift_x,
   input  logic signed [11:0]      req_shift_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_red,
   output logic [7:0]              rsp_out_green,
   output logic [7:0]              rsp_out_blue,
   output logic [7:0]              rsp_out_alpha,
   output logic [7:0]              rsp_gray_level,
   output logic                    rsp_is_inside,
   output logic                    rsp_frame_end,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW      = $clog2(MAX_SIDE);
   localparam int POS_W   = (CW + FRAC_BITS + 2 > 13) ? CW + FRAC_BITS + 2 : 13;
   localparam int DIFF_W  = ((POS_W > CENTER_W) ? POS_W : CENTER_W) + 1;
   localparam int MAG_W   = DIFF_W + 1;
   localparam int RB_W    = ((FRAC_BITS + 1 > RADIUS_W + 1) ? FRAC_BITS + 1 : RADIUS_W + 1) + 1;
   localparam int BOUND_W = 2 * RB_W;

   csr_type                   csr;
   logic [BOUND_W-1:0]        outer_bound;
   logic [BOUND_W-1:0]        inner_bound;
   logic [CW-1:0]             col;
   logic [CW-1:0]             row;
   logic                      pos_frame_end;

   logic                      accept;
   logic                      out_free;
   logic                      s1_move;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic signed [POS_W-1:0]   px;
   logic signed [POS_W-1:0]   py;
   logic signed [DIFF_W-1:0]  dx;
   logic signed [DIFF_W-1:0]  dy;
   logic [DIFF_W-1:0]         abs_x;
   logic [DIFF_W-1:0]         abs_y;
   logic [WSUM_W-1:0]         wsum_in;

   logic [MAG_W-1:0]          mag_x_ff;
   logic [MAG_W-1:0]          mag_y_ff;
   logic [WSUM_W-1:0]         wsum_ff;
   color_type                 color_ff;
   logic                      frame_end_ff;
   result_type                result;
   result_type                result_ff;

   crpm_csr #(
      .FRAC_BITS (FRAC_BITS),
      .BOUND_W   (BOUND_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .csr         (csr),
      .outer_bound (outer_bound),
      .inner_bound (inner_bound)
   );

   crpm_raster #(
      .MAX_SIDE (MAX_SIDE),
      .CW       (CW)
   ) u_raster (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_width  (csr.frame_width),
      .frame_height (csr.frame_height),
      .col          (col),
      .row          (row),
      .frame_end    (pos_frame_end)
   );

   // Two-entry pipeline: the input register moves on whenever the result
   // register is empty or being drained this cycle.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s1_move      = s1_valid_ff && out_free;
      req_ready    = !s1_valid_ff || out_free;
      accept       = req_valid && req_ready;
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample point offset from the center, and its doubled magnitude,
   // are formed ahead of the input register.
   always_comb begin
      px      = $signed(POS_W'(col) << FRAC_BITS) + POS_W'(req_shift_x);
      py      = $signed(POS_W'(row) << FRAC_BITS) + POS_W'(req_shift_y);
      dx      = DIFF_W'(px) - DIFF_W'(csr.center_x);
      dy      = DIFF_W'(py) - DIFF_W'(csr.center_y);
      abs_x   = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
      abs_y   = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
      wsum_in = WSUM_W'(req_color_red) * WSUM_W'(LUMA_R)
              + WSUM_W'(req_color_green) * WSUM_W'(LUMA_G)
              + WSUM_W'(req_color_blue) * WSUM_W'(LUMA_B);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_x_ff       <= {abs_x, 1'b0};
         mag_y_ff       <= {abs_y, 1'b0};
         wsum_ff        <= wsum_in;
         color_ff.red   <= req_color_red;
         color_ff.green <= req_color_green;
         color_ff.blue  <= req_color_blue;
         color_ff.alpha <= req_color_alpha;
         frame_end_ff   <= pos_frame_end;
      end
   end

   crpm_eval #(
      .MAG_W   (MAG_W),
      .BOUND_W (BOUND_W)
   ) u_eval (
      .mag_x       (mag_x_ff),
      .mag_y       (mag_y_ff),
      .outer_bound (outer_bound),
      .inner_bound (inner_bound),
      .fill_mode   (csr.fill_mode),
      .color       (color_ff),
      .wsum        (wsum_ff),
      .frame_end   (frame_end_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = result_ff.color.red;
   assign rsp_out_green  = result_ff.color.green;
   assign rsp_out_blue   = result_ff.color.blue;
   assign rsp_out_alpha  = result_ff.color.alpha;
   assign rsp_gray_level = result_ff.gray_level;
   assign rsp_is_inside  = result_ff.is_inside;
   assign rsp_frame_end  = result_ff.frame_end;

   // An outside pixel is transparent black with no luminance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_inside |->
         rsp_out_red == 8'd0 && rsp_out_green == 8'd0 && rsp_out_blue == 8'd0 &&
         rsp_out_alpha == 8'd0 && rsp_gray_level == 8'd0)
      else $error("outside pixel carries color");

   // The word after the last pixel of a frame starts at the origin.
   assert property (@(posedge clock) disable iff (reset)
      accept && pos_frame_end |=> col == '0 && row == '0)
      else $error("raster did not wrap after frame end");

   // A word leaving the input register lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("word lost between input and result registers");

endmodule

@@ sv/crpm_csr.sv @@
module crpm_csr
   import crpm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int BOUND_W   = 36
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output csr_type                csr,
   output logic [BOUND_W-1:0]     outer_bound,
   output logic [BOUND_W-1:0]     inner_bound
);

   localparam int RB_W = BOUND_W / 2;
   localparam logic [RB_W-1:0] ONE = {{(RB_W-1){1'b0}}, 1'b1} << FRAC_BITS;

   csr_type              csr_ff;
   logic [RB_W-1:0]      twice_r;
   logic [RB_W-1:0]      outer_root;
   logic [RB_W-1:0]      inner_root;
   logic [BOUND_W-1:0]   outer_ff;
   logic [BOUND_W-1:0]   inner_ff;
   logic [BOUND_W-1:0]   outer_in;
   logic [BOUND_W-1:0]   inner_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.center_x     <= '0;
         csr_ff.center_y     <= '0;
         csr_ff.radius       <= '0;
         csr_ff.fill_mode    <= 1'b0;
         csr_ff.frame_width  <= FRAME_RESET;
         csr_ff.frame_height <= FRAME_RESET;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_CENTER_X:     csr_ff.center_x     <= $signed(csr_wdata[CENTER_W-1:0]);
            REG_CENTER_Y:     csr_ff.center_y     <= $signed(csr_wdata[CENTER_W-1:0]);
            REG_RADIUS:       csr_ff.radius       <= csr_wdata[RADIUS_W-1:0];
            REG_FILL_MODE:    csr_ff.fill_mode    <= csr_wdata[0];
            REG_FRAME_WIDTH:  csr_ff.frame_width  <= csr_wdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: csr_ff.frame_height <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // Squared bounds at twice the resolution, so the half pixel is exact.
   // They are registered, so they follow the radius register in the next cycle.
   always_comb begin
      twice_r    = RB_W'({csr_ff.radius, 1'b0});
      outer_root = twice_r + ONE;
      inner_root = (twice_r >= ONE) ? (twice_r - ONE) : (ONE - twice_r);
      outer_in   = BOUND_W'(outer_root) * BOUND_W'(outer_root);
      inner_in   = BOUND_W'(inner_root) * BOUND_W'(inner_root);
   end

   always_ff @(posedge clock) begin
      outer_ff <= outer_in;
      inner_ff <= inner_in;
   end

   assign csr         = csr_ff;
   assign outer_bound = outer_ff;
   assign inner_bound = inner_ff;

endmodule

@@ sv/crpm_raster.sv @@
module crpm_raster
   import crpm_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF,
   parameter int CW       = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [FRAME_W-1:0] frame_width,
   input  logic [FRAME_W-1:0] frame_height,
   output logic [CW-1:0]      col,
   output logic [CW-1:0]      row,
   output logic               frame_end
);

   logic [CW-1:0] col_ff;
   logic [CW-1:0] row_ff;
   logic [CW-1:0] col_in;
   logic [CW-1:0] row_in;
   logic [CW-1:0] last_c;
   logic [CW-1:0] last_r;
   logic          last_col;
   logic          last_row;

   // A counter at or past the last position (the frame shrank mid-frame)
   // is taken as the last position.
   always_comb begin
      last_c   = CW'(clamp_side(frame_width, MAX_SIDE) - 1);
      last_r   = CW'(clamp_side(frame_height, MAX_SIDE) - 1);
      last_col = col_ff >= last_c;
      last_row = row_ff >= last_r;
      col      = last_col ? last_c : col_ff;
      row      = last_row ? last_r : row_ff;
      frame_end = last_col && last_row;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row + 1'b1;
      end else begin
         col_in = col + 1'b1;
         row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ sv/crpm_eval.sv @@
module crpm_eval
   import crpm_pkg::*;
#(
   parameter int MAG_W   = 20,
   parameter int BOUND_W = 36
) (
   input  logic [MAG_W-1:0]   mag_x,
   input  logic [MAG_W-1:0]   mag_y,
   input  logic [BOUND_W-1:0] outer_bound,
   input  logic [BOUND_W-1:0] inner_bound,
   input  logic               fill_mode,
   input  color_type          color,
   input  logic [WSUM_W-1:0]  wsum,
   input  logic               frame_end,
   output result_type         result
);

   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int PROD_W = WSUM_W + RECIP_W;

   logic [SQ_W-1:0]   sq_x;
   logic [SQ_W-1:0]   sq_y;
   logic [DIST_W-1:0] dist_sum;
   logic [DIST_W-1:0] outer_ext;
   logic [DIST_W-1:0] inner_ext;
   logic [PROD_W-1:0] prod;
   logic              hit;

   always_comb begin
      sq_x      = SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y      = SQ_W'(mag_y) * SQ_W'(mag_y);
      dist_sum  = DIST_W'(sq_x) + DIST_W'(sq_y);
      outer_ext = DIST_W'(outer_bound);
      inner_ext = DIST_W'(inner_bound);
      if (fill_mode) begin
         hit = dist_sum <= outer_ext;
      end else begin
         hit = (dist_sum >= inner_ext) && (dist_sum <= outer_ext);
      end
      prod = PROD_W'(wsum) * PROD_W'(RECIP);

      result.is_inside  = hit;
      result.frame_end  = frame_end;
      result.color      = hit ? color : '0;
      result.gray_level = hit ? prod[RECIP_SHIFT +: 8] : 8'd0;
   end

endmodule
